// ===== hdl/gap_framed_telemetry_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the telemetry receiver.
// ----------------------------------------------------------------------------
`ifndef GAP_FRAMED_TELEMETRY_RECEIVER_ASSERT_SVH
`define GAP_FRAMED_TELEMETRY_RECEIVER_ASSERT_SVH
`ifndef ASSERT_OFF
`define GFTR_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("gftr: same-cycle check failed");
`define GFTR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("gftr: next-cycle check failed");
`else
`define GFTR_ASSERT_SAME(label, clk, rst, pre, post)
`define GFTR_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== hdl/gftr_pkg.sv =====
// ----------------------------------------------------------------------------
// gftr_pkg
// Shared constants, codes and types of the telemetry receiver.
// ----------------------------------------------------------------------------
package gftr_pkg;

   localparam int unsigned MAX_LINE   = 128;
   localparam int unsigned FRAME_LEN  = 11;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned IDX_W      = $clog2(FRAME_LEN);
   localparam int unsigned STATUS_POS = 2;
   localparam int unsigned TEMP_POS   = 3;
   localparam int unsigned AUX_POS    = 7;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [7:0]  STREAK_MAX              = 8'hFF;
   localparam logic [15:0] GAP_MS_RESET            = 16'd35;
   localparam logic [7:0]  HEADER_BYTE_RESET       = 8'h68;
   localparam logic [7:0]  CYCLE_END_CODE_RESET    = 8'h11;
   localparam logic [7:0]  EMPTY_STATUS_CODE_RESET = 8'h00;
   localparam logic [7:0]  EMPTY_AUX_CODE_RESET    = 8'h00;
   localparam logic [7:0]  DEBOUNCE_FRAMES_RESET   = 8'd3;

   typedef enum logic [2:0] {
      OP_BYTE            = 3'd0,
      OP_TICK            = 3'd1,
      OP_SESSION_CLEAR   = 3'd2,
      OP_HANDSHAKE_CLEAR = 3'd3,
      OP_TAKE_EVENT      = 3'd4
   } op_code_type;

   typedef enum logic [2:0] {
      CMD_BYTE,
      CMD_TICK,
      CMD_SESSION_CLEAR,
      CMD_HANDSHAKE_CLEAR,
      CMD_TAKE_EVENT,
      CMD_IDLE
   } cmd_kind_type;

   typedef enum logic [2:0] {
      CSR_GAP_MS            = 3'd0,
      CSR_HEADER_BYTE       = 3'd1,
      CSR_CYCLE_END_CODE    = 3'd2,
      CSR_EMPTY_STATUS_CODE = 3'd3,
      CSR_EMPTY_AUX_CODE    = 3'd4,
      CSR_DEBOUNCE_FRAMES   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      EVT_NONE  = 2'd0,
      EVT_EMPTY = 2'd1,
      EVT_OK    = 2'd2
   } tank_event_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data_byte;
      logic [31:0]  now_ms;
   } cmd_type;

   typedef struct packed {
      logic                   wr_en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_type;

   typedef struct packed {
      logic           frame_accepted;
      logic           telemetry_valid;
      logic [7:0]     status_code;
      logic [7:0]     aux_code;
      logic [7:0]     live_temp;
      logic           close_seen;
      logic           tank_stable_ready;
      logic           tank_empty;
      tank_event_type tank_transition;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

// ===== hdl/gftr_front.sv =====
// ----------------------------------------------------------------------------
// gftr_front
// Request intake: handshake and classification of operation codes.
// ----------------------------------------------------------------------------
module gftr_front (
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_operation,
   input  logic [7:0]                  req_data_byte,
   input  logic [31:0]                 req_now_ms,
   input  gftr_pkg::queue_status_type  q_status,
   output logic                        push,
   output gftr_pkg::cmd_type           push_cmd
);

   gftr_pkg::cmd_kind_type kind;

   always_comb begin
      case (gftr_pkg::op_code_type'(req_operation))
         gftr_pkg::OP_BYTE:            kind = gftr_pkg::CMD_BYTE;
         gftr_pkg::OP_TICK:            kind = gftr_pkg::CMD_TICK;
         gftr_pkg::OP_SESSION_CLEAR:   kind = gftr_pkg::CMD_SESSION_CLEAR;
         gftr_pkg::OP_HANDSHAKE_CLEAR: kind = gftr_pkg::CMD_HANDSHAKE_CLEAR;
         gftr_pkg::OP_TAKE_EVENT:      kind = gftr_pkg::CMD_TAKE_EVENT;
         default:                      kind = gftr_pkg::CMD_IDLE;
      endcase
   end

   assign req_ready          = !q_status.full;
   assign push               = req_valid && !q_status.full;
   assign push_cmd.kind      = kind;
   assign push_cmd.data_byte = req_data_byte;
   assign push_cmd.now_ms    = req_now_ms;

endmodule

// ===== hdl/gftr_queue.sv =====
// ----------------------------------------------------------------------------
// gftr_queue
// Two-entry command queue between intake and execution.
// ----------------------------------------------------------------------------
`include "gap_framed_telemetry_receiver_assert.svh"

module gftr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gftr_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output gftr_pkg::cmd_type          pop_cmd,
   output gftr_pkg::queue_status_type status
);

   gftr_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd      = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.valid = (count_ff != 2'd0);

   `GFTR_ASSERT_SAME(a_pop_not_empty, clock, reset, pop, count_ff != 2'd0)
   `GFTR_ASSERT_SAME(a_push_not_full, clock, reset, count_ff == 2'd2, !push)
   `GFTR_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1)

endmodule

// ===== hdl/gftr_back.sv =====
// ----------------------------------------------------------------------------
// gftr_back
// Execution: line assembly, frame check, telemetry latch, tank debounce,
// configuration registers and the response register.
// ----------------------------------------------------------------------------
`include "gap_framed_telemetry_receiver_assert.svh"

module gftr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  gftr_pkg::csr_type          csr,
   input  gftr_pkg::queue_status_type q_status,
   input  gftr_pkg::cmd_type          cmd,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output gftr_pkg::rsp_type          rsp
);

   localparam logic [gftr_pkg::COUNT_W-1:0] MaxLineCount =
      gftr_pkg::COUNT_W'(gftr_pkg::MAX_LINE);
   localparam logic [gftr_pkg::COUNT_W-1:0] FrameCount =
      gftr_pkg::COUNT_W'(gftr_pkg::FRAME_LEN);
   localparam logic [gftr_pkg::COUNT_W-1:0] SumCount =
      gftr_pkg::COUNT_W'(gftr_pkg::FRAME_LEN - 1);

   logic [15:0] gap_ms_ff;
   logic [7:0]  header_byte_ff;
   logic [7:0]  cycle_end_code_ff;
   logic [7:0]  empty_status_code_ff;
   logic [7:0]  empty_aux_code_ff;
   logic [7:0]  debounce_frames_ff;

   logic [7:0]  frame_bytes_ff [gftr_pkg::FRAME_LEN];
   logic                        fb_we;
   logic [gftr_pkg::IDX_W-1:0]  fb_idx;

   logic [gftr_pkg::COUNT_W-1:0] line_count_ff, line_count_in;
   logic                         line_open_ff, line_open_in;
   logic [31:0]                  last_byte_time_ff, last_byte_time_in;
   logic [7:0]                   head_sum_ff, head_sum_in;
   logic                         telem_valid_ff, telem_valid_in;
   logic [7:0]                   telem_status_ff, telem_status_in;
   logic [7:0]                   telem_aux_ff, telem_aux_in;
   logic [7:0]                   telem_temp_ff, telem_temp_in;
   logic                         cycle_closed_ff, cycle_closed_in;
   logic                         deb_active_ff, deb_active_in;
   logic                         deb_target_ff, deb_target_in;
   logic [7:0]                   deb_streak_ff, deb_streak_in;
   logic                         stable_empty_ff, stable_empty_in;
   logic                         stable_ready_ff, stable_ready_in;
   gftr_pkg::tank_event_type     pending_ff, pending_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   gftr_pkg::rsp_type            rsp_ff, rsp_in;

   logic [gftr_pkg::COUNT_W-1:0] base_count;
   logic [7:0]                   base_sum;
   logic [31:0]                  elapsed;
   logic                         gap_met;
   logic                         frame_ok;
   logic                         raw_empty;
   logic [7:0]                   streak_inc;
   logic                         accepted;

   assign pop = q_status.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (line_count_ff < MaxLineCount) begin
         base_count = line_count_ff;
         base_sum   = head_sum_ff;
      end else begin
         base_count = '0;
         base_sum   = 8'd0;
      end
      elapsed    = cmd.now_ms - last_byte_time_ff;
      gap_met    = elapsed >= {16'd0, gap_ms_ff};
      frame_ok   = line_open_ff && (line_count_ff == FrameCount) &&
                   (frame_bytes_ff[0] == header_byte_ff) &&
                   (frame_bytes_ff[gftr_pkg::FRAME_LEN-1] == head_sum_ff);
      raw_empty  = (frame_bytes_ff[gftr_pkg::STATUS_POS] == empty_status_code_ff) &&
                   (frame_bytes_ff[gftr_pkg::AUX_POS] == empty_aux_code_ff);
      streak_inc = (deb_streak_ff < gftr_pkg::STREAK_MAX) ? deb_streak_ff + 8'd1
                                                          : deb_streak_ff;
   end

   always_comb begin
      line_count_in     = line_count_ff;
      line_open_in      = line_open_ff;
      last_byte_time_in = last_byte_time_ff;
      head_sum_in       = head_sum_ff;
      telem_valid_in    = telem_valid_ff;
      telem_status_in   = telem_status_ff;
      telem_aux_in      = telem_aux_ff;
      telem_temp_in     = telem_temp_ff;
      cycle_closed_in   = cycle_closed_ff;
      deb_active_in     = deb_active_ff;
      deb_target_in     = deb_target_ff;
      deb_streak_in     = deb_streak_ff;
      stable_empty_in   = stable_empty_ff;
      stable_ready_in   = stable_ready_ff;
      pending_in        = pending_ff;
      fb_we             = 1'b0;
      fb_idx            = base_count[gftr_pkg::IDX_W-1:0];
      accepted          = 1'b0;

      if (pop) begin
         case (cmd.kind)
            gftr_pkg::CMD_BYTE: begin
               fb_we             = base_count < FrameCount;
               head_sum_in       = (base_count < SumCount) ? base_sum + cmd.data_byte
                                                           : base_sum;
               line_count_in     = base_count + gftr_pkg::COUNT_W'(1);
               line_open_in      = 1'b1;
               last_byte_time_in = cmd.now_ms;
            end
            gftr_pkg::CMD_TICK: begin
               if (line_open_ff && gap_met) begin
                  line_count_in     = '0;
                  line_open_in      = 1'b0;
                  last_byte_time_in = 32'd0;
                  head_sum_in       = 8'd0;
                  if (frame_ok) begin
                     accepted        = 1'b1;
                     telem_valid_in  = 1'b1;
                     telem_status_in = frame_bytes_ff[gftr_pkg::STATUS_POS];
                     telem_aux_in    = frame_bytes_ff[gftr_pkg::AUX_POS];
                     telem_temp_in   = frame_bytes_ff[gftr_pkg::TEMP_POS];
                     if (frame_bytes_ff[gftr_pkg::STATUS_POS] == cycle_end_code_ff) begin
                        cycle_closed_in = 1'b1;
                     end
                     if (!deb_active_ff || (raw_empty != deb_target_ff)) begin
                        deb_active_in = 1'b1;
                        deb_target_in = raw_empty;
                        deb_streak_in = 8'd1;
                     end else begin
                        deb_streak_in = streak_inc;
                        if (streak_inc >= debounce_frames_ff) begin
                           stable_ready_in = 1'b1;
                           if (raw_empty != stable_empty_ff) begin
                              stable_empty_in = raw_empty;
                              pending_in = raw_empty ? gftr_pkg::EVT_EMPTY
                                                     : gftr_pkg::EVT_OK;
                           end
                        end
                     end
                  end
               end
            end
            gftr_pkg::CMD_SESSION_CLEAR: begin
               line_count_in     = '0;
               line_open_in      = 1'b0;
               last_byte_time_in = 32'd0;
               head_sum_in       = 8'd0;
               telem_valid_in    = 1'b0;
               telem_status_in   = 8'd0;
               telem_aux_in      = 8'd0;
               telem_temp_in     = 8'd0;
               cycle_closed_in   = 1'b0;
            end
            gftr_pkg::CMD_HANDSHAKE_CLEAR: begin
               line_count_in     = '0;
               line_open_in      = 1'b0;
               last_byte_time_in = 32'd0;
               head_sum_in       = 8'd0;
               telem_valid_in    = 1'b0;
               telem_status_in   = 8'd0;
               telem_aux_in      = 8'd0;
               telem_temp_in     = 8'd0;
               deb_active_in     = 1'b0;
               deb_target_in     = 1'b0;
               deb_streak_in     = 8'd0;
               stable_empty_in   = 1'b0;
               stable_ready_in   = 1'b0;
               pending_in        = gftr_pkg::EVT_NONE;
            end
            gftr_pkg::CMD_TAKE_EVENT: begin
               pending_in = gftr_pkg::EVT_NONE;
            end
            default: begin
            end
         endcase
      end

      rsp_in.frame_accepted    = accepted;
      rsp_in.telemetry_valid   = telem_valid_in;
      rsp_in.status_code       = telem_status_in;
      rsp_in.aux_code          = telem_aux_in;
      rsp_in.live_temp         = telem_temp_in;
      rsp_in.close_seen        = cycle_closed_in;
      rsp_in.tank_stable_ready = stable_ready_in;
      rsp_in.tank_empty        = stable_ready_in && stable_empty_in;
      rsp_in.tank_transition   = (cmd.kind == gftr_pkg::CMD_TAKE_EVENT) ? pending_ff
                                                                         : pending_in;
      rsp_valid_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ms_ff            <= gftr_pkg::GAP_MS_RESET;
         header_byte_ff       <= gftr_pkg::HEADER_BYTE_RESET;
         cycle_end_code_ff    <= gftr_pkg::CYCLE_END_CODE_RESET;
         empty_status_code_ff <= gftr_pkg::EMPTY_STATUS_CODE_RESET;
         empty_aux_code_ff    <= gftr_pkg::EMPTY_AUX_CODE_RESET;
         debounce_frames_ff   <= gftr_pkg::DEBOUNCE_FRAMES_RESET;
      end else if (csr.wr_en) begin
         case (gftr_pkg::csr_index_type'(csr.index))
            gftr_pkg::CSR_GAP_MS:            gap_ms_ff            <= csr.wdata;
            gftr_pkg::CSR_HEADER_BYTE:       header_byte_ff       <= csr.wdata[7:0];
            gftr_pkg::CSR_CYCLE_END_CODE:    cycle_end_code_ff    <= csr.wdata[7:0];
            gftr_pkg::CSR_EMPTY_STATUS_CODE: empty_status_code_ff <= csr.wdata[7:0];
            gftr_pkg::CSR_EMPTY_AUX_CODE:    empty_aux_code_ff    <= csr.wdata[7:0];
            gftr_pkg::CSR_DEBOUNCE_FRAMES:   debounce_frames_ff   <= csr.wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (fb_we) begin
         frame_bytes_ff[fb_idx] <= cmd.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff     <= '0;
         line_open_ff      <= 1'b0;
         last_byte_time_ff <= 32'd0;
         head_sum_ff       <= 8'd0;
         telem_valid_ff    <= 1'b0;
         telem_status_ff   <= 8'd0;
         telem_aux_ff      <= 8'd0;
         telem_temp_ff     <= 8'd0;
         cycle_closed_ff   <= 1'b0;
         deb_active_ff     <= 1'b0;
         deb_target_ff     <= 1'b0;
         deb_streak_ff     <= 8'd0;
         stable_empty_ff   <= 1'b0;
         stable_ready_ff   <= 1'b0;
         pending_ff        <= gftr_pkg::EVT_NONE;
         rsp_valid_ff      <= 1'b0;
      end else begin
         line_count_ff     <= line_count_in;
         line_open_ff      <= line_open_in;
         last_byte_time_ff <= last_byte_time_in;
         head_sum_ff       <= head_sum_in;
         telem_valid_ff    <= telem_valid_in;
         telem_status_ff   <= telem_status_in;
         telem_aux_ff      <= telem_aux_in;
         telem_temp_ff     <= telem_temp_in;
         cycle_closed_ff   <= cycle_closed_in;
         deb_active_ff     <= deb_active_in;
         deb_target_ff     <= deb_target_in;
         deb_streak_ff     <= deb_streak_in;
         stable_empty_ff   <= stable_empty_in;
         stable_ready_ff   <= stable_ready_in;
         pending_ff        <= pending_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `GFTR_ASSERT_SAME(a_open_tracks_count, clock, reset, 1'b1, line_open_ff == (line_count_ff != '0))
   `GFTR_ASSERT_SAME(a_empty_needs_ready, clock, reset, stable_empty_ff, stable_ready_ff)
   `GFTR_ASSERT_SAME(a_stall_holds_pop, clock, reset, rsp_valid_ff && !rsp_ready, !pop)
   `GFTR_ASSERT_SAME(a_accept_latches, clock, reset, rsp_valid_ff && rsp_ff.frame_accepted, rsp_ff.telemetry_valid)

endmodule

// ===== hdl/gap_framed_telemetry_receiver.sv =====
// ----------------------------------------------------------------------------
// gap_framed_telemetry_receiver
// Gap-framed UART telemetry receiver with frame check and tank debounce.
// ----------------------------------------------------------------------------
//  channel   ports                         direction  transfer
//  request   req_valid/req_ready + fields  in         valid && ready
//  response  rsp_valid/rsp_ready + fields  out        valid && ready
//  csr       csr_wr_en/csr_index/csr_wdata in         wr_en, no wait
//
//  One request per cycle sustained while responses are taken; each request gives one response.
//  A request is registered in the two-entry command queue, then the
//  execution stage loads the response register.
//  Reset is synchronous; configuration returns to its defaults, no sweep.
//  A stalled response holds execution; the queue absorbs two requests,
//  then req_ready drops.
// ----------------------------------------------------------------------------
module gap_framed_telemetry_receiver (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_operation,
   input  logic [7:0]                       req_data_byte,
   input  logic [31:0]                      req_now_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_frame_accepted,
   output logic                             rsp_telemetry_valid,
   output logic [7:0]                       rsp_status_code,
   output logic [7:0]                       rsp_aux_code,
   output logic [7:0]                       rsp_live_temp,
   output logic                             rsp_close_seen,
   output logic                             rsp_tank_stable_ready,
   output logic                             rsp_tank_empty,
   output logic [1:0]                       rsp_tank_transition,
   input  logic                             csr_wr_en,
   input  logic [gftr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gftr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   gftr_pkg::queue_status_type q_status;
   gftr_pkg::cmd_type          push_cmd;
   gftr_pkg::cmd_type          pop_cmd;
   gftr_pkg::csr_type          csr;
   gftr_pkg::rsp_type          rsp;
   logic                       push;
   logic                       pop;

   assign csr.wr_en = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   gftr_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .req_now_ms    (req_now_ms),
      .q_status      (q_status),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   gftr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   gftr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .q_status  (q_status),
      .cmd       (pop_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_frame_accepted    = rsp.frame_accepted;
   assign rsp_telemetry_valid   = rsp.telemetry_valid;
   assign rsp_status_code       = rsp.status_code;
   assign rsp_aux_code          = rsp.aux_code;
   assign rsp_live_temp         = rsp.live_temp;
   assign rsp_close_seen        = rsp.close_seen;
   assign rsp_tank_stable_ready = rsp.tank_stable_ready;
   assign rsp_tank_empty        = rsp.tank_empty;
   assign rsp_tank_transition   = rsp.tank_transition;

endmodule

// ===== dv/tb_gap_framed_telemetry_receiver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gap_framed_telemetry_receiver
// Self-checking bench for the gap-framed telemetry receiver. A short table of
// directed requests opens the run. Randomised framed traffic follows over
// several register settings and handshake pressures. Every response is
// compared field by field with a fixed value where a directed row gives
// one, else with a local model of the frame, latch and debounce logic.
// ----------------------------------------------------------------------------
module tb_gap_framed_telemetry_receiver;

   localparam logic [2:0] OP_SPARE = 3'd5;
   localparam int DIRECTED_ROWS = 23;
   localparam int PHASES = 5;
   localparam int PHASE_REQUESTS = 110;

   localparam gftr_pkg::rsp_type QUIET = '0;
   localparam gftr_pkg::rsp_type FIRST_FRAME =
      {1'b1, 1'b1, 8'h11, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0, gftr_pkg::EVT_NONE};
   localparam gftr_pkg::rsp_type FRAME_HELD =
      {1'b0, 1'b1, 8'h11, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0, gftr_pkg::EVT_NONE};

   typedef struct packed {
      logic [2:0]        op;
      logic [7:0]        data;
      logic [31:0]       now;
      logic              fixed;
      gftr_pkg::rsp_type rsp;
   } row_type;

   typedef struct packed {
      logic [6:0]  send_idle;
      logic [6:0]  stall;
      logic [15:0] gap;
      logic [7:0]  header;
      logic [7:0]  close_code;
      logic [7:0]  empty_status;
      logic [7:0]  empty_aux;
      logic [7:0]  frames;
   } phase_plan_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation = gftr_pkg::OP_BYTE;
   logic [7:0]  req_data_byte = 8'h00;
   logic [31:0] req_now_ms = 32'h0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_frame_accepted;
   logic        rsp_telemetry_valid;
   logic [7:0]  rsp_status_code;
   logic [7:0]  rsp_aux_code;
   logic [7:0]  rsp_live_temp;
   logic        rsp_close_seen;
   logic        rsp_tank_stable_ready;
   logic        rsp_tank_empty;
   logic [1:0]  rsp_tank_transition;
   logic        csr_wr_en = 1'b0;
   logic [gftr_pkg::CSR_INDEX_W-1:0] csr_index = gftr_pkg::CSR_GAP_MS;
   logic [gftr_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // receiver model
   logic [15:0]              cfg_gap;
   logic [7:0]               cfg_header;
   logic [7:0]               cfg_close_code;
   logic [7:0]               cfg_empty_status;
   logic [7:0]               cfg_empty_aux;
   logic [7:0]               cfg_frames;
   logic [7:0]               rx_count;
   logic                     rx_open;
   logic [31:0]              rx_last;
   logic [7:0]               rx_bytes [0:gftr_pkg::FRAME_LEN-1];
   logic [7:0]               rx_sum;
   logic                     tm_valid;
   logic [7:0]               tm_status;
   logic [7:0]               tm_aux;
   logic [7:0]               tm_temp;
   logic                     session_closed;
   logic                     tk_active;
   logic                     tk_target;
   logic [7:0]               tk_streak;
   logic                     tk_empty;
   logic                     tk_ready;
   gftr_pkg::tank_event_type tk_event;

   gftr_pkg::rsp_type telemetry_due [$];
   gftr_pkg::rsp_type want;
   int                mismatches = 0;
   int                requests_sent = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   logic [31:0]       cur_ms = 32'h0;
   row_type           directed_rows [DIRECTED_ROWS];
   phase_plan_type    plans [PHASES];

   gap_framed_telemetry_receiver uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_data_byte         (req_data_byte),
      .req_now_ms            (req_now_ms),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_frame_accepted    (rsp_frame_accepted),
      .rsp_telemetry_valid   (rsp_telemetry_valid),
      .rsp_status_code       (rsp_status_code),
      .rsp_aux_code          (rsp_aux_code),
      .rsp_live_temp         (rsp_live_temp),
      .rsp_close_seen        (rsp_close_seen),
      .rsp_tank_stable_ready (rsp_tank_stable_ready),
      .rsp_tank_empty        (rsp_tank_empty),
      .rsp_tank_transition   (rsp_tank_transition),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic void drop_line();
      rx_count = '0;
      rx_open  = 1'b0;
      rx_last  = '0;
      rx_sum   = '0;
   endfunction

   function automatic void clear_telemetry();
      tm_valid  = 1'b0;
      tm_status = '0;
      tm_aux    = '0;
      tm_temp   = '0;
   endfunction

   function automatic gftr_pkg::rsp_type predict_telemetry(input logic [2:0] op,
                                                           input logic [7:0] data,
                                                           input logic [31:0] now);
      gftr_pkg::rsp_type        outcome;
      logic [31:0]              silence;
      logic                     empty_raw;
      gftr_pkg::tank_event_type shown;
      outcome = '0;
      case (op)
         gftr_pkg::OP_BYTE: begin
            // restart an overfull line with this byte
            if (rx_count >= gftr_pkg::MAX_LINE) drop_line();
            rx_open = 1'b1;
            if (rx_count < gftr_pkg::FRAME_LEN) rx_bytes[rx_count] = data;
            if (rx_count < gftr_pkg::FRAME_LEN - 1) rx_sum = rx_sum + data;
            rx_count = rx_count + 8'd1;
            rx_last  = now;
         end
         gftr_pkg::OP_TICK: begin
            silence = now - rx_last;
            if (rx_open && silence >= cfg_gap) begin
               if (rx_count == gftr_pkg::FRAME_LEN && rx_bytes[0] == cfg_header &&
                   rx_bytes[gftr_pkg::FRAME_LEN-1] == rx_sum) begin
                  outcome.frame_accepted = 1'b1;
                  tm_valid  = 1'b1;
                  tm_status = rx_bytes[gftr_pkg::STATUS_POS];
                  tm_aux    = rx_bytes[gftr_pkg::AUX_POS];
                  tm_temp   = rx_bytes[gftr_pkg::TEMP_POS];
                  empty_raw = (rx_bytes[gftr_pkg::STATUS_POS] == cfg_empty_status) &&
                              (rx_bytes[gftr_pkg::AUX_POS] == cfg_empty_aux);
                  if (!tk_active || empty_raw != tk_target) begin
                     tk_active = 1'b1;
                     tk_target = empty_raw;
                     tk_streak = 8'd1;
                  end else begin
                     if (tk_streak != gftr_pkg::STREAK_MAX) tk_streak = tk_streak + 8'd1;
                     if (tk_streak >= cfg_frames) begin
                        tk_ready = 1'b1;
                        if (empty_raw != tk_empty) begin
                           tk_empty = empty_raw;
                           tk_event = empty_raw ? gftr_pkg::EVT_EMPTY : gftr_pkg::EVT_OK;
                        end
                     end
                  end
                  if (tm_status == cfg_close_code) session_closed = 1'b1;
               end
               drop_line();
            end
         end
         gftr_pkg::OP_SESSION_CLEAR: begin
            session_closed = 1'b0;
            clear_telemetry();
            drop_line();
         end
         gftr_pkg::OP_HANDSHAKE_CLEAR: begin
            drop_line();
            clear_telemetry();
            tk_active = 1'b0;
            tk_target = 1'b0;
            tk_streak = '0;
            tk_empty  = 1'b0;
            tk_ready  = 1'b0;
            tk_event  = gftr_pkg::EVT_NONE;
         end
         default: begin
         end
      endcase
      shown = tk_event;
      if (op == gftr_pkg::OP_TAKE_EVENT) tk_event = gftr_pkg::EVT_NONE;
      outcome.telemetry_valid   = tm_valid;
      outcome.status_code       = tm_status;
      outcome.aux_code          = tm_aux;
      outcome.live_temp         = tm_temp;
      outcome.close_seen        = session_closed;
      outcome.tank_stable_ready = tk_ready;
      outcome.tank_empty        = tk_ready && tk_empty;
      outcome.tank_transition   = shown;
      return outcome;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %0h, actual %0h", $time, name, want_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (telemetry_due.size() == 0) begin
            $display("%0t: response expected none, actual status %0h", $time,
                     rsp_status_code);
            mismatches++;
         end else begin
            want = telemetry_due.pop_front();
            check_field("frame_accepted", 32'(want.frame_accepted),
                        32'(rsp_frame_accepted));
            check_field("telemetry_valid", 32'(want.telemetry_valid),
                        32'(rsp_telemetry_valid));
            check_field("status_code", 32'(want.status_code), 32'(rsp_status_code));
            check_field("aux_code", 32'(want.aux_code), 32'(rsp_aux_code));
            check_field("live_temp", 32'(want.live_temp), 32'(rsp_live_temp));
            check_field("close_seen", 32'(want.close_seen), 32'(rsp_close_seen));
            check_field("tank_stable_ready", 32'(want.tank_stable_ready),
                        32'(rsp_tank_stable_ready));
            check_field("tank_empty", 32'(want.tank_empty), 32'(rsp_tank_empty));
            check_field("tank_transition", 32'(want.tank_transition),
                        32'(rsp_tank_transition));
         end
      end
   end

   task automatic send_request(input logic [2:0] op, input logic [7:0] data,
                               input logic [31:0] now, input logic fixed,
                               input gftr_pkg::rsp_type fixed_rsp);
      gftr_pkg::rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      req_now_ms    <= now;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predicted = predict_telemetry(op, data, now);
      telemetry_due.push_back(fixed ? fixed_rsp : predicted);
      requests_sent++;
   endtask

   task automatic send_line(input int len, input logic [7:0] status,
                            input logic [7:0] aux, input logic bad_header,
                            input logic bad_sum);
      int         i;
      logic [7:0] sum;
      logic [7:0] value;
      logic [7:0] flip;
      sum  = '0;
      flip = 8'($urandom_range(1, 255));
      for (i = 0; i < len; i++) begin
         value = 8'($urandom);
         if (i == 0) value = bad_header ? cfg_header ^ flip : cfg_header;
         else if (i == gftr_pkg::STATUS_POS) value = status;
         else if (i == gftr_pkg::AUX_POS) value = aux;
         else if (i == gftr_pkg::FRAME_LEN - 1) value = bad_sum ? sum ^ flip : sum;
         if (i < gftr_pkg::FRAME_LEN - 1) sum = sum + value;
         cur_ms = cur_ms + $urandom_range(0, 2);
         send_request(gftr_pkg::OP_BYTE, value, cur_ms, 1'b0, QUIET);
      end
      // probe one millisecond short of the gap now and then
      if (cfg_gap != 0 && $urandom_range(3) == 0)
         send_request(gftr_pkg::OP_TICK, 8'($urandom), cur_ms + cfg_gap - 1, 1'b0, QUIET);
      cur_ms = cur_ms + cfg_gap + $urandom_range(0, 2);
      send_request(gftr_pkg::OP_TICK, 8'($urandom), cur_ms, 1'b0, QUIET);
   endtask

   task automatic write_register(input gftr_pkg::csr_index_type idx,
                                 input logic [15:0] value);
      logic [7:0] junk;
      junk = 8'($urandom);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (idx == gftr_pkg::CSR_GAP_MS) ? value : {junk, value[7:0]};
      @(posedge clock);
      case (idx)
         gftr_pkg::CSR_GAP_MS:            cfg_gap = value;
         gftr_pkg::CSR_HEADER_BYTE:       cfg_header = value[7:0];
         gftr_pkg::CSR_CYCLE_END_CODE:    cfg_close_code = value[7:0];
         gftr_pkg::CSR_EMPTY_STATUS_CODE: cfg_empty_status = value[7:0];
         gftr_pkg::CSR_EMPTY_AUX_CODE:    cfg_empty_aux = value[7:0];
         gftr_pkg::CSR_DEBOUNCE_FRAMES:   cfg_frames = value[7:0];
         default: begin
         end
      endcase
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (telemetry_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      #4_000_000;
      $display("gap_framed_telemetry_receiver verification failed");
      $finish;
   end

   initial begin
      int          i;
      int          phase;
      int          pick;
      int          run_left;
      int          phase_goal;
      logic        run_empty;
      logic [7:0]  status;
      logic [7:0]  aux;

      cfg_gap          = gftr_pkg::GAP_MS_RESET;
      cfg_header       = gftr_pkg::HEADER_BYTE_RESET;
      cfg_close_code   = gftr_pkg::CYCLE_END_CODE_RESET;
      cfg_empty_status = gftr_pkg::EMPTY_STATUS_CODE_RESET;
      cfg_empty_aux    = gftr_pkg::EMPTY_AUX_CODE_RESET;
      cfg_frames       = gftr_pkg::DEBOUNCE_FRAMES_RESET;
      for (i = 0; i < gftr_pkg::FRAME_LEN; i++) rx_bytes[i] = '0;
      drop_line();
      clear_telemetry();
      session_closed = 1'b0;
      tk_active      = 1'b0;
      tk_target      = 1'b0;
      tk_streak      = '0;
      tk_empty       = 1'b0;
      tk_ready       = 1'b0;
      tk_event       = gftr_pkg::EVT_NONE;
      run_left       = 0;
      run_empty      = 1'b0;

      directed_rows[0]  = {gftr_pkg::OP_TICK, 8'h00, 32'h0000_0000, 1'b1, QUIET};
      directed_rows[1]  = {OP_SPARE, 8'hFF, 32'hFFFF_FFFF, 1'b1, QUIET};
      directed_rows[2]  = {gftr_pkg::OP_TAKE_EVENT, 8'h00, 32'h0000_0000, 1'b1, QUIET};
      directed_rows[3]  = {gftr_pkg::OP_BYTE, 8'h68, 32'd1000, 1'b0, QUIET};
      directed_rows[4]  = {gftr_pkg::OP_BYTE, 8'h00, 32'd1001, 1'b0, QUIET};
      directed_rows[5]  = {gftr_pkg::OP_BYTE, 8'h11, 32'd1002, 1'b0, QUIET};
      directed_rows[6]  = {gftr_pkg::OP_BYTE, 8'hFF, 32'd1003, 1'b0, QUIET};
      directed_rows[7]  = {gftr_pkg::OP_BYTE, 8'h01, 32'd1004, 1'b0, QUIET};
      directed_rows[8]  = {gftr_pkg::OP_BYTE, 8'h02, 32'd1005, 1'b0, QUIET};
      directed_rows[9]  = {gftr_pkg::OP_BYTE, 8'h03, 32'd1006, 1'b0, QUIET};
      directed_rows[10] = {gftr_pkg::OP_BYTE, 8'h00, 32'd1007, 1'b0, QUIET};
      directed_rows[11] = {gftr_pkg::OP_BYTE, 8'h04, 32'd1008, 1'b0, QUIET};
      directed_rows[12] = {gftr_pkg::OP_BYTE, 8'h05, 32'd1009, 1'b0, QUIET};
      directed_rows[13] = {gftr_pkg::OP_BYTE, 8'h87, 32'd1010, 1'b0, QUIET};
      directed_rows[14] = {gftr_pkg::OP_TICK, 8'hA5, 32'd1044, 1'b0, QUIET};
      directed_rows[15] = {gftr_pkg::OP_TICK, 8'h00, 32'd1045, 1'b1, FIRST_FRAME};
      directed_rows[16] = {gftr_pkg::OP_BYTE, 8'h00, 32'hFFFF_FFF0, 1'b0, QUIET};
      directed_rows[17] = {gftr_pkg::OP_TICK, 8'h00, 32'h0000_0012, 1'b0, QUIET};
      directed_rows[18] = {gftr_pkg::OP_TICK, 8'h00, 32'h0000_0013, 1'b1, FRAME_HELD};
      directed_rows[19] = {gftr_pkg::OP_SESSION_CLEAR, 8'h5A, 32'h0000_0020, 1'b1, QUIET};
      directed_rows[20] = {gftr_pkg::OP_BYTE, 8'hFF, 32'h0000_0005, 1'b0, QUIET};
      directed_rows[21] = {gftr_pkg::OP_HANDSHAKE_CLEAR, 8'hC3, 32'h8000_0000, 1'b1, QUIET};
      directed_rows[22] = {gftr_pkg::OP_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1, QUIET};

      plans[0] = {7'd0, 7'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'd1};
      plans[1] = {7'd64, 7'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'd2};
      plans[2] = {7'd0, 7'd64, 16'd35, 8'h68, 8'h11, 8'h20, 8'h5A, 8'd3};
      plans[3] = {7'd34, 7'd34, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'd1};
      plans[3].gap          = 16'($urandom_range(1, 300));
      plans[3].header       = 8'($urandom);
      plans[3].close_code   = 8'($urandom);
      plans[3].empty_status = 8'($urandom);
      plans[3].empty_aux    = 8'($urandom);
      plans[3].frames       = 8'($urandom_range(1, 4));
      plans[4] = {7'd0, 7'd0, 16'd1, 8'hAA, 8'h55, 8'h00, 8'h00, 8'hFF};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++)
         send_request(directed_rows[i].op, directed_rows[i].data, directed_rows[i].now,
                      directed_rows[i].fixed, directed_rows[i].rsp);

      for (phase = 0; phase < PHASES; phase++) begin
         drain_responses();
         write_register(gftr_pkg::CSR_GAP_MS, plans[phase].gap);
         write_register(gftr_pkg::CSR_HEADER_BYTE, 16'(plans[phase].header));
         write_register(gftr_pkg::CSR_CYCLE_END_CODE, 16'(plans[phase].close_code));
         write_register(gftr_pkg::CSR_EMPTY_STATUS_CODE, 16'(plans[phase].empty_status));
         write_register(gftr_pkg::CSR_EMPTY_AUX_CODE, 16'(plans[phase].empty_aux));
         write_register(gftr_pkg::CSR_DEBOUNCE_FRAMES, 16'(plans[phase].frames));
         csr_wr_en     <= 1'b0;
         send_idle_pct = int'(plans[phase].send_idle);
         stall_pct     = int'(plans[phase].stall);
         cur_ms        = $urandom;

         if (phase == 2) begin
            // fill the line so that the header byte restarts it
            repeat (gftr_pkg::MAX_LINE) begin
               cur_ms = cur_ms + $urandom_range(0, 1);
               send_request(gftr_pkg::OP_BYTE, 8'($urandom), cur_ms, 1'b0, QUIET);
            end
            send_line(gftr_pkg::FRAME_LEN, cfg_close_code, 8'($urandom), 1'b0, 1'b0);
         end

         phase_goal = requests_sent + PHASE_REQUESTS;
         while (requests_sent < phase_goal) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               if (run_left == 0) begin
                  run_empty = 1'($urandom_range(1));
                  run_left  = $urandom_range(1, 5);
               end
               run_left--;
               if (run_empty) begin
                  status = cfg_empty_status;
                  aux    = cfg_empty_aux;
               end else begin
                  pick   = $urandom_range(2);
                  status = (pick == 0) ? cfg_close_code :
                           (pick == 1) ? cfg_empty_status : 8'($urandom);
                  aux    = 8'($urandom);
                  if (status == cfg_empty_status && aux == cfg_empty_aux) aux = ~aux;
               end
               send_line(gftr_pkg::FRAME_LEN, status, aux, 1'b0, 1'b0);
            end else if (pick < 68) begin
               case ($urandom_range(3))
                  0: send_line(gftr_pkg::FRAME_LEN, 8'($urandom), 8'($urandom),
                               1'b1, 1'b0);
                  1: send_line(gftr_pkg::FRAME_LEN, 8'($urandom), 8'($urandom),
                               1'b0, 1'b1);
                  2: send_line($urandom_range(1, gftr_pkg::FRAME_LEN - 1), 8'($urandom),
                               8'($urandom), 1'b0, 1'b0);
                  default: send_line($urandom_range(gftr_pkg::FRAME_LEN + 1, 20),
                                     8'($urandom), 8'($urandom), 1'b0, 1'b0);
               endcase
            end else if (pick < 76) begin
               send_request(gftr_pkg::OP_TAKE_EVENT, 8'($urandom), cur_ms, 1'b0, QUIET);
            end else if (pick < 80) begin
               send_request(gftr_pkg::OP_SESSION_CLEAR, 8'($urandom), cur_ms, 1'b0, QUIET);
            end else if (pick < 83) begin
               send_request(gftr_pkg::OP_HANDSHAKE_CLEAR, 8'($urandom), cur_ms, 1'b0,
                            QUIET);
            end else if (pick < 90) begin
               cur_ms = cur_ms + $urandom_range(0, cfg_gap + 1);
               send_request(gftr_pkg::OP_TICK, 8'($urandom), cur_ms, 1'b0, QUIET);
            end else begin
               send_request(3'($urandom_range(0, 7)), 8'($urandom), $urandom, 1'b0,
                            QUIET);
            end
         end
      end

      drain_responses();
      if (mismatches == 0) begin
         $display("gap_framed_telemetry_receiver verification clean");
      end else begin
         $display("gap_framed_telemetry_receiver verification failed");
      end
      $finish;
   end

endmodule
